FILE: rtl/core/triangle_height_rasterizer_assert.svh
// Assertion macros shared by the triangle height rasterizer RTL.
`ifndef TRIANGLE_HEIGHT_RASTERIZER_ASSERT_SVH
`define TRIANGLE_HEIGHT_RASTERIZER_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define THR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rasterizer same-cycle check failed");

// Consequence must hold in the cycle after the antecedent.
`define THR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rasterizer next-cycle check failed");

`endif

FILE: rtl/core/thr_pkg.sv
// Shared types, constants and helpers of the triangle height rasterizer.
`timescale 1ns / 1ps
`default_nettype none
package thr_pkg;
   localparam int DEF_MAX_DIM = 256;
   localparam int CFG_W       = 9;
   localparam int XYW         = 21;
   localparam int ZW          = 32;
   localparam int RCW         = 8;
   localparam int TRW         = 13;
   localparam int SW          = 36;
   localparam int QW          = 32;
   localparam int CSR_AW      = 4;
   localparam int CSR_DW      = 32;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_DRAW  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
   localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
   localparam logic [1:0] REG_MASK_MODE   = 2'd2;

   localparam logic [CFG_W-1:0] GRID_DIM_RESET = 9'd256;
   localparam logic [ZW-1:0]    HEIGHT_ONE     = 32'h0001_0000;
   localparam logic signed [SW-1:0] SAT_MAX = 36'sh0_7FFF_FFFF;
   localparam logic signed [SW-1:0] SAT_MIN = -36'sh0_8000_0000;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_RMUL, ST_RADDR, ST_RDATA,
      ST_D0, ST_D1, ST_D2, ST_BOX, ST_PIX,
      ST_U0, ST_U1, ST_V0, ST_V1, ST_TEST,
      ST_DIVU, ST_TU, ST_DIVV, ST_TV, ST_NEXT, ST_DONE
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // Divide a vertex coordinate by 256, truncating toward zero.
   function automatic logic signed [TRW-1:0] trunc_px(input logic signed [XYW-1:0] v);
      logic signed [XYW:0] ext;
      logic [XYW:0] mag;
      logic [XYW:0] q;
      ext = (XYW+1)'(v);
      mag = v[XYW-1] ? -ext : ext;
      q = mag >> 8;
      return v[XYW-1] ? -TRW'(q) : TRW'(q);
   endfunction
endpackage
`default_nettype wire

FILE: rtl/core/thr_if.sv
// Request and response channel interfaces of the triangle height rasterizer.
`timescale 1ns / 1ps
`default_nettype none
interface thr_req_if import thr_pkg::*; ();
   logic valid;
   logic ready;
   logic [1:0] operation;
   logic signed [XYW-1:0] first_x;
   logic signed [XYW-1:0] first_y;
   logic signed [ZW-1:0] first_z;
   logic signed [XYW-1:0] second_x;
   logic signed [XYW-1:0] second_y;
   logic signed [ZW-1:0] second_z;
   logic signed [XYW-1:0] third_x;
   logic signed [XYW-1:0] third_y;
   logic signed [ZW-1:0] third_z;
   logic [RCW-1:0] read_column;
   logic [RCW-1:0] read_row;

   modport source (output valid, operation, first_x, first_y, first_z, second_x, second_y,
                   second_z, third_x, third_y, third_z, read_column, read_row,
                   input ready);
   modport sink (input valid, operation, first_x, first_y, first_z, second_x, second_y,
                 second_z, third_x, third_y, third_z, read_column, read_row,
                 output ready);
endinterface

interface thr_rsp_if import thr_pkg::*; ();
   logic valid;
   logic ready;
   logic signed [ZW-1:0] height_out;
   logic covered_out;
   logic any_written;

   modport source (output valid, height_out, covered_out, any_written, input ready);
   modport sink (input valid, height_out, covered_out, any_written, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/triangle_height_rasterizer.sv
// Clear zeroes every cell; read multiplies, addresses and fetches one cell.
// Draw sets up the triangle, then walks the clipped box: an already covered pixel is skipped,
// an outside or mask-mode pixel is tested, and an interpolated one runs two 32-step divides.
// One request is in work at a time; the next is taken once the response is registered.
// Synchronous reset clears control state and runs a clearing pass over all MAX_DIM*MAX_DIM cells.
`timescale 1ns / 1ps
`default_nettype none
`include "triangle_height_rasterizer_assert.svh"
module triangle_height_rasterizer import thr_pkg::*; #(
   parameter int MAX_DIM = DEF_MAX_DIM
) (
   input  logic              clock,
   input  logic              reset,
   thr_req_if.sink           req_bus,
   thr_rsp_if.source         rsp_bus,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);
   localparam int XW    = $clog2(MAX_DIM);
   localparam int DW    = $clog2(MAX_DIM) + 1;
   localparam int AW    = 2 * XW;
   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int BW    = (XW + 2 > 14) ? XW + 2 : 14;
   localparam int CW    = (XW + 10 > 23) ? XW + 10 : 23;
   localparam int PW    = 2 * CW + 2;
   localparam int MW    = (CW > ZW + 2) ? CW : ZW + 2;
   localparam int RW    = ZW + 1;

   // Configuration registers.
   logic [CFG_W-1:0] grid_width_ff, grid_width_in;
   logic [CFG_W-1:0] grid_height_ff, grid_height_in;
   logic             mask_mode_ff, mask_mode_in;
   logic             csr_write;

   logic [DW-1:0] w_eff, h_eff;

   state_type state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic          clr_op_ff, clr_op_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          wrote_ff, wrote_in;

   logic signed [CW-1:0] x1_ff, x1_in, y1_ff, y1_in;
   logic signed [CW-1:0] v0x_ff, v0x_in, v0y_ff, v0y_in, e1x_ff, e1x_in, e1y_ff, e1y_in;
   logic signed [ZW-1:0] z1_ff, z1_in;
   logic signed [ZW:0]   dz31_ff, dz31_in, dz21_ff, dz21_in;
   logic signed [BW-1:0] lox_ff, lox_in, hix_ff, hix_in, loy_ff, loy_in, hiy_ff, hiy_in;
   logic [RCW-1:0]       col_ff, col_in, row_ff, row_in;
   logic signed [PW-1:0] acc_ff, acc_in, u_ff, u_in, v_ff, v_in, dd_ff, dd_in;
   logic                 dneg_ff, dneg_in;
   logic [XW-1:0]        px_ff, px_in, py_ff, py_in;
   logic [AW-1:0]        idx_ff, idx_in, row0_ff, row0_in;
   logic signed [SW-1:0] sum_ff, sum_in;
   logic signed [ZW-1:0] res_height_ff, res_height_in;
   logic                 res_cov_ff, res_cov_in;
   logic signed [ZW-1:0] out_height_ff, out_height_in;
   logic                 out_cov_ff, out_cov_in;
   logic                 out_any_ff, out_any_in;

   // Shared datapath.
   logic signed [MW-1:0]   mul_a, mul_b;
   logic signed [2*MW-1:0] prod;
   logic                   div_start;
   logic [PW-1:0]          div_num;
   div_stat_type           div_st;
   logic [QW-1:0]          div_q;
   logic                   ram_we;
   logic [AW-1:0]          ram_waddr, ram_raddr;
   logic [RW-1:0]          ram_wdata, ram_rdata;

   logic signed [TRW-1:0] tx1, tx2, tx3, ty1, ty2, ty3;
   logic signed [BW-1:0]  bmin_x, bmax_x, bmin_y, bmax_y, wm1, hm1;
   logic signed [CW-1:0]  ex, ey;
   logic signed [PW-1:0]  d_val, v_raw, u_adj, v_adj;
   logic                  pix_hit;
   logic signed [2*MW-1:0] rnd;
   logic signed [SW-1:0]  term, sum_new, sum_sat;

   thr_mul #(.MW(MW)) u_mul (.clock(clock), .a(mul_a), .b(mul_b), .p(prod));

   thr_div #(.NW(PW)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num),
      .den(dd_ff), .stat(div_st), .quot(div_q)
   );

   thr_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
      .raddr(ram_raddr), .rdata(ram_rdata)
   );

   // Configuration port.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      mask_mode_in   = mask_mode_ff;
      if (csr_write) begin
         case (paddr[3:2])
            REG_GRID_WIDTH:  grid_width_in  = pwdata[CFG_W-1:0];
            REG_GRID_HEIGHT: grid_height_in = pwdata[CFG_W-1:0];
            REG_MASK_MODE:   mask_mode_in   = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_GRID_WIDTH:  prdata = CSR_DW'(grid_width_ff);
         REG_GRID_HEIGHT: prdata = CSR_DW'(grid_height_ff);
         REG_MASK_MODE:   prdata = CSR_DW'(mask_mode_ff);
         default:         prdata = '0;
      endcase
   end

   // A zero size counts as one, an oversized one as the maximum.
   assign w_eff = (grid_width_ff == '0) ? DW'(1) :
                  (32'(grid_width_ff) > MAX_DIM) ? DW'(MAX_DIM) : DW'(grid_width_ff);
   assign h_eff = (grid_height_ff == '0) ? DW'(1) :
                  (32'(grid_height_ff) > MAX_DIM) ? DW'(MAX_DIM) : DW'(grid_height_ff);

   // Bounding box of the incoming triangle, clipped to the grid.
   always_comb begin
      tx1 = trunc_px(req_bus.first_x);
      tx2 = trunc_px(req_bus.second_x);
      tx3 = trunc_px(req_bus.third_x);
      ty1 = trunc_px(req_bus.first_y);
      ty2 = trunc_px(req_bus.second_y);
      ty3 = trunc_px(req_bus.third_y);
      bmin_x = BW'(tx1);
      if (BW'(tx2) < bmin_x) bmin_x = BW'(tx2);
      if (BW'(tx3) < bmin_x) bmin_x = BW'(tx3);
      bmax_x = BW'(tx1);
      if (BW'(tx2) > bmax_x) bmax_x = BW'(tx2);
      if (BW'(tx3) > bmax_x) bmax_x = BW'(tx3);
      bmin_y = BW'(ty1);
      if (BW'(ty2) < bmin_y) bmin_y = BW'(ty2);
      if (BW'(ty3) < bmin_y) bmin_y = BW'(ty3);
      bmax_y = BW'(ty1);
      if (BW'(ty2) > bmax_y) bmax_y = BW'(ty2);
      if (BW'(ty3) > bmax_y) bmax_y = BW'(ty3);
      wm1 = BW'(w_eff) - BW'(1);
      hm1 = BW'(h_eff) - BW'(1);
      if (bmin_x < 0) bmin_x = '0;
      if (bmin_y < 0) bmin_y = '0;
      if (bmax_x > wm1) bmax_x = wm1;
      if (bmax_y > hm1) bmax_y = hm1;
   end

   // Pixel centre relative to the first vertex, and per-pixel arithmetic.
   assign ex    = $signed(CW'({px_ff, 8'h80})) - x1_ff;
   assign ey    = $signed(CW'({py_ff, 8'h80})) - y1_ff;
   assign d_val = acc_ff - PW'(prod);
   assign v_raw = acc_ff - PW'(prod);
   assign u_adj = dneg_ff ? -u_ff : u_ff;
   assign v_adj = dneg_ff ? -v_raw : v_raw;
   assign pix_hit = !u_adj[PW-1] && !v_adj[PW-1] && ((u_adj + v_adj) <= dd_ff);
   // Product rounded to nearest with ties up and scaled to 16.16.
   assign rnd   = prod + $signed({{(2*MW-31){1'b0}}, 1'b1, 30'b0});
   assign term  = SW'(rnd >>> 31);
   assign sum_new = sum_ff + term;
   assign sum_sat = (sum_new > SAT_MAX) ? SAT_MAX : (sum_new < SAT_MIN) ? SAT_MIN : sum_new;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      clr_op_in     = clr_op_ff;
      rsp_valid_in  = rsp_valid_ff;
      wrote_in      = wrote_ff;
      x1_in = x1_ff;  y1_in = y1_ff;  z1_in = z1_ff;
      v0x_in = v0x_ff; v0y_in = v0y_ff; e1x_in = e1x_ff; e1y_in = e1y_ff;
      dz31_in = dz31_ff; dz21_in = dz21_ff;
      lox_in = lox_ff; hix_in = hix_ff; loy_in = loy_ff; hiy_in = hiy_ff;
      col_in = col_ff; row_in = row_ff;
      acc_in = acc_ff; u_in = u_ff; v_in = v_ff; dd_in = dd_ff; dneg_in = dneg_ff;
      px_in = px_ff; py_in = py_ff; idx_in = idx_ff; row0_in = row0_ff;
      sum_in = sum_ff;
      res_height_in = res_height_ff;
      res_cov_in    = res_cov_ff;
      out_height_in = out_height_ff;
      out_cov_in    = out_cov_ff;
      out_any_in    = out_any_ff;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      div_num   = PW'(v_ff);
      ram_we    = 1'b0;
      ram_waddr = idx_ff;
      ram_wdata = '0;
      ram_raddr = idx_ff;
      req_bus.ready = 1'b0;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = clr_op_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               x1_in   = CW'(req_bus.first_x);
               y1_in   = CW'(req_bus.first_y);
               z1_in   = req_bus.first_z;
               v0x_in  = CW'(req_bus.third_x) - CW'(req_bus.first_x);
               v0y_in  = CW'(req_bus.third_y) - CW'(req_bus.first_y);
               e1x_in  = CW'(req_bus.second_x) - CW'(req_bus.first_x);
               e1y_in  = CW'(req_bus.second_y) - CW'(req_bus.first_y);
               dz31_in = (ZW+1)'(req_bus.third_z) - (ZW+1)'(req_bus.first_z);
               dz21_in = (ZW+1)'(req_bus.second_z) - (ZW+1)'(req_bus.first_z);
               lox_in  = bmin_x;
               hix_in  = bmax_x;
               loy_in  = bmin_y;
               hiy_in  = bmax_y;
               col_in  = req_bus.read_column;
               row_in  = req_bus.read_row;
               wrote_in      = 1'b0;
               res_height_in = '0;
               res_cov_in    = 1'b0;
               case (req_bus.operation)
                  OP_CLEAR: begin
                     clr_in    = '0;
                     clr_op_in = 1'b1;
                     state_in  = ST_CLEAR;
                  end
                  OP_DRAW: state_in = ST_D0;
                  OP_READ: state_in = ST_RMUL;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_RMUL: begin
            mul_a    = MW'(w_eff);
            mul_b    = MW'(row_ff);
            state_in = ST_RADDR;
         end
         ST_RADDR: begin
            if (32'(col_ff) < 32'(w_eff) && 32'(row_ff) < 32'(h_eff)) begin
               ram_raddr = AW'(col_ff) + AW'(prod);
               state_in  = ST_RDATA;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_RDATA: begin
            res_height_in = ram_rdata[ZW-1:0];
            res_cov_in    = ram_rdata[ZW];
            state_in      = ST_DONE;
         end
         ST_D0: begin
            mul_a    = MW'(v0x_ff);
            mul_b    = MW'(e1y_ff);
            state_in = ST_D1;
         end
         ST_D1: begin
            acc_in   = PW'(prod);
            mul_a    = MW'(v0y_ff);
            mul_b    = MW'(e1x_ff);
            state_in = ST_D2;
         end
         ST_D2: begin
            dneg_in = d_val[PW-1];
            dd_in   = d_val[PW-1] ? -d_val : d_val;
            // A degenerate triangle or an empty clipped box writes nothing.
            if (d_val == '0 || lox_ff > hix_ff || loy_ff > hiy_ff) begin
               state_in = ST_DONE;
            end else begin
               mul_a    = MW'(w_eff);
               mul_b    = MW'(loy_ff);
               state_in = ST_BOX;
            end
         end
         ST_BOX: begin
            row0_in  = AW'(lox_ff) + AW'(prod);
            idx_in   = AW'(lox_ff) + AW'(prod);
            px_in    = XW'(lox_ff);
            py_in    = XW'(loy_ff);
            state_in = ST_PIX;
         end
         ST_PIX: begin
            ram_raddr = idx_ff;
            state_in  = ST_U0;
         end
         ST_U0: begin
            if (ram_rdata[ZW]) begin
               state_in = ST_NEXT;
            end else begin
               mul_a    = MW'(ex);
               mul_b    = MW'(e1y_ff);
               state_in = ST_U1;
            end
         end
         ST_U1: begin
            acc_in   = PW'(prod);
            mul_a    = MW'(ey);
            mul_b    = MW'(e1x_ff);
            state_in = ST_V0;
         end
         ST_V0: begin
            u_in     = acc_ff - PW'(prod);
            mul_a    = MW'(v0x_ff);
            mul_b    = MW'(ey);
            state_in = ST_V1;
         end
         ST_V1: begin
            acc_in   = PW'(prod);
            mul_a    = MW'(v0y_ff);
            mul_b    = MW'(ex);
            state_in = ST_TEST;
         end
         ST_TEST: begin
            if (!pix_hit) begin
               state_in = ST_NEXT;
            end else if (mask_mode_ff) begin
               ram_we    = 1'b1;
               ram_wdata = {1'b1, HEIGHT_ONE};
               wrote_in  = 1'b1;
               state_in  = ST_NEXT;
            end else begin
               u_in      = u_adj;
               v_in      = v_adj;
               div_start = 1'b1;
               div_num   = PW'(u_adj);
               state_in  = ST_DIVU;
            end
         end
         ST_DIVU: begin
            if (div_st.done) begin
               mul_a    = MW'(div_q);
               mul_b    = MW'(dz31_ff);
               state_in = ST_TU;
            end
         end
         ST_TU: begin
            sum_in    = SW'(z1_ff) + term;
            div_start = 1'b1;
            div_num   = PW'(v_ff);
            state_in  = ST_DIVV;
         end
         ST_DIVV: begin
            if (div_st.done) begin
               mul_a    = MW'(div_q);
               mul_b    = MW'(dz21_ff);
               state_in = ST_TV;
            end
         end
         ST_TV: begin
            ram_we    = 1'b1;
            ram_wdata = {1'b1, sum_sat[ZW-1:0]};
            wrote_in  = 1'b1;
            state_in  = ST_NEXT;
         end
         ST_NEXT: begin
            state_in = ST_PIX;
            if (BW'(py_ff) == hiy_ff) begin
               if (BW'(px_ff) == hix_ff) begin
                  state_in = ST_DONE;
               end else begin
                  px_in   = px_ff + 1'b1;
                  py_in   = XW'(loy_ff);
                  row0_in = row0_ff + 1'b1;
                  idx_in  = row0_ff + 1'b1;
               end
            end else begin
               py_in  = py_ff + 1'b1;
               idx_in = idx_ff + AW'(w_eff);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               out_height_in = res_height_ff;
               out_cov_in    = res_cov_ff;
               out_any_in    = wrote_ff;
               clr_op_in     = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         clr_op_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         wrote_ff       <= 1'b0;
         grid_width_ff  <= GRID_DIM_RESET;
         grid_height_ff <= GRID_DIM_RESET;
         mask_mode_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         clr_op_ff      <= clr_op_in;
         rsp_valid_ff   <= rsp_valid_in;
         wrote_ff       <= wrote_in;
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         mask_mode_ff   <= mask_mode_in;
      end
   end

   always_ff @(posedge clock) begin
      x1_ff <= x1_in;  y1_ff <= y1_in;  z1_ff <= z1_in;
      v0x_ff <= v0x_in; v0y_ff <= v0y_in; e1x_ff <= e1x_in; e1y_ff <= e1y_in;
      dz31_ff <= dz31_in; dz21_ff <= dz21_in;
      lox_ff <= lox_in; hix_ff <= hix_in; loy_ff <= loy_in; hiy_ff <= hiy_in;
      col_ff <= col_in; row_ff <= row_in;
      acc_ff <= acc_in; u_ff <= u_in; v_ff <= v_in; dd_ff <= dd_in; dneg_ff <= dneg_in;
      px_ff <= px_in; py_ff <= py_in; idx_ff <= idx_in; row0_ff <= row0_in;
      sum_ff <= sum_in;
      res_height_ff <= res_height_in;
      res_cov_ff    <= res_cov_in;
      out_height_ff <= out_height_in;
      out_cov_ff    <= out_cov_in;
      out_any_ff    <= out_any_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.height_out  = out_height_ff;
   assign rsp_bus.covered_out = out_cov_ff;
   assign rsp_bus.any_written = out_any_ff;

   `THR_ASSERT_SAME(a_no_write_when_idle, clock, reset, ram_we, state_ff != ST_IDLE && state_ff != ST_DONE)
   `THR_ASSERT_SAME(a_div_only_in_div_state, clock, reset, div_st.busy, state_ff == ST_DIVU || state_ff == ST_DIVV)
   `THR_ASSERT_NEXT(a_pixel_write_sets_flag, clock, reset, ram_we && state_ff != ST_CLEAR, wrote_ff)
endmodule
`default_nettype wire

FILE: rtl/core/thr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module thr_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
      rdata_ff <= store_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

FILE: rtl/core/thr_mul.sv
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none
module thr_mul #(
   parameter int MW = 34
) (
   input  logic                   clock,
   input  logic signed [MW-1:0]   a,
   input  logic signed [MW-1:0]   b,
   output logic signed [2*MW-1:0] p
);
   logic signed [2*MW-1:0] p_ff;

   always_ff @(posedge clock) begin
      p_ff <= a * b;
   end

   assign p = p_ff;
endmodule
`default_nettype wire

FILE: rtl/core/thr_div.sv
// Restoring divider giving num/den as a fraction with 31 fraction bits.
`timescale 1ns / 1ps
`default_nettype none
module thr_div import thr_pkg::*; #(
   parameter int NW = 48
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [NW-1:0]  num,
   input  logic [NW-1:0]  den,
   output div_stat_type   stat,
   output logic [QW-1:0]  quot
);
   localparam int CNTW = $clog2(QW);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [NW:0]     rem_ff, rem_in;
   logic [NW-1:0]   den_ff, den_in;
   logic [QW-1:0]   q_ff, q_in;
   logic [NW:0]     shifted;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      // The first step decides the integer bit and does not shift.
      shifted = (cnt_ff == '0) ? rem_ff : {rem_ff[NW-1:0], 1'b0};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = (NW+1)'(num);
         den_in  = den;
         q_in    = '0;
      end else if (busy_ff) begin
         if (shifted >= (NW+1)'(den_ff)) begin
            rem_in = shifted - (NW+1)'(den_ff);
            q_in   = {q_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            q_in   = {q_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (&cnt_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = q_ff;
endmodule
`default_nettype wire
